/* hdl/qwdp_pkg.sv */
// Shared types and constants for the quantized-weight dot product unit.
`timescale 1ns / 1ps

package qwdp_pkg;

  // Elements per weight block; the position counter wraps here.
  localparam int unsigned BlockElems = 32;
  localparam int unsigned PosW       = 8;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Weight code width selected by the mode register.
  localparam logic [1:0] ModeTwoBit   = 2'd0;
  localparam logic [1:0] ModeFourBit  = 2'd1;
  localparam logic [1:0] ModeEightBit = 2'd2;

  // Masks for the packed sub-byte codes.
  localparam logic [7:0] TwoBitMask  = 8'h03;
  localparam logic [7:0] FourBitMask = 8'h0F;

  localparam int unsigned WeightW = 25;
  localparam int unsigned ProdW   = 41;
  localparam int unsigned SumW    = 48;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic signed [15:0] act;
    logic signed [8:0]  code;
    logic signed [15:0] scale;
    logic signed [23:0] zero;
    logic               last;
  } item_t;

  // Queue status seen by both parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* hdl/qwdp_front.sv */
// Front part: accepts items, holds the mode and the position, extracts the weight code.
`timescale 1ns / 1ps

module qwdp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [63:0]           in_data_i,
  input  logic                  in_last_i,
  input  qwdp_pkg::q_stat_t     q_stat_i,
  output logic                  push_o,
  output qwdp_pkg::item_t       push_item_o
);

  logic [1:0]                  mode_q;
  logic [qwdp_pkg::PosW-1:0]   pos_q, pos_d;
  logic [qwdp_pkg::PosW:0]     pos_inc;
  logic [7:0]                  byte_w;
  logic [7:0]                  shifted;
  logic signed [8:0]           code;
  logic                        eight_bit;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;
  assign byte_w     = in_data_i[23:16];

  // Mode register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qwdp_pkg::ModeFourBit;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Code selection within the packed byte; the unused mode behaves as eight-bit.
  always_comb begin
    shifted   = byte_w;
    code      = $signed({1'b0, byte_w});
    eight_bit = 1'b0;
    unique case (mode_q)
      qwdp_pkg::ModeTwoBit: begin
        shifted = byte_w >> {pos_q[1:0], 1'b0};
        code    = $signed({1'b0, shifted & qwdp_pkg::TwoBitMask});
      end
      qwdp_pkg::ModeFourBit: begin
        shifted = byte_w >> {pos_q[0], 2'b00};
        code    = $signed({1'b0, shifted & qwdp_pkg::FourBitMask});
      end
      default: begin
        eight_bit = 1'b1;
        code      = $signed({byte_w[7], byte_w});
      end
    endcase
  end

  // Classified item; the zero point drops out in eight-bit mode.
  always_comb begin
    push_item_o.act   = $signed(in_data_i[15:0]);
    push_item_o.code  = code;
    push_item_o.scale = $signed(in_data_i[39:24]);
    push_item_o.zero  = eight_bit ? 24'sd0 : $signed(in_data_i[63:40]);
    push_item_o.last  = in_last_i;
  end

  // Position counter: wraps at the block size and clears at each row end.
  always_comb begin
    pos_inc = {1'b0, pos_q} + 1'b1;
    pos_d   = pos_q;
    if (push_o) begin
      if (in_last_i || (pos_inc >= (qwdp_pkg::PosW+1)'(qwdp_pkg::BlockElems))) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc[qwdp_pkg::PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

/* hdl/qwdp_queue.sv */
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module qwdp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  qwdp_pkg::item_t       push_item_i,
  input  logic                  pop_i,
  output qwdp_pkg::item_t       head_o,
  output qwdp_pkg::q_stat_t     stat_o
);

  qwdp_pkg::item_t                 mem_q [qwdp_pkg::QueueDepth];
  logic [qwdp_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [qwdp_pkg::QueuePtrW:0]    count_q;

  assign stat_o.full  = (count_q == (qwdp_pkg::QueuePtrW+1)'(qwdp_pkg::QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/qwdp_back.sv */
// Back part: dequantizes, multiplies and accumulates with saturation, holds the result.
`timescale 1ns / 1ps

module qwdp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qwdp_pkg::item_t       head_i,
  input  qwdp_pkg::q_stat_t     q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [47:0]           out_data_o,
  output logic                  out_user_o
);

  logic                                  advance;
  logic                                  w_valid_q, p_valid_q, out_valid_q;
  logic signed [qwdp_pkg::WeightW-1:0]   code_x, scale_x, zero_x, weight_d;
  logic signed [qwdp_pkg::WeightW-1:0]   w_weight_q;
  logic signed [15:0]                    w_act_q;
  logic                                  w_last_q, p_last_q;
  logic signed [qwdp_pkg::ProdW-1:0]     act_x, weight_x, prod_d, p_prod_q;
  logic signed [qwdp_pkg::SumW-1:0]      acc_q, sat_sum;
  logic signed [qwdp_pkg::SumW:0]        sum_wide;
  logic                                  clip_q, ovf, clip_now;
  logic [47:0]                           out_data_q;
  logic                                  out_user_q;

  // The whole pipeline moves unless a result waits on a stalled receiver.
  assign advance     = !(out_valid_q && !out_ready_i);
  assign pop_o       = advance && !q_stat_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // Dequantized weight: zero point plus code times scale.
  always_comb begin
    code_x   = qwdp_pkg::WeightW'(head_i.code);
    scale_x  = qwdp_pkg::WeightW'(head_i.scale);
    zero_x   = qwdp_pkg::WeightW'(head_i.zero);
    weight_d = zero_x + code_x * scale_x;
  end

  // Activation times weight, exact.
  always_comb begin
    act_x    = qwdp_pkg::ProdW'(w_act_q);
    weight_x = qwdp_pkg::ProdW'(w_weight_q);
    prod_d   = act_x * weight_x;
  end

  // Accumulate and clamp to the 48-bit range.
  always_comb begin
    sum_wide = (qwdp_pkg::SumW+1)'(acc_q) + (qwdp_pkg::SumW+1)'(p_prod_q);
    ovf      = (sum_wide[qwdp_pkg::SumW] != sum_wide[qwdp_pkg::SumW-1]);
    if (!ovf) begin
      sat_sum = sum_wide[qwdp_pkg::SumW-1:0];
    end else if (sum_wide[qwdp_pkg::SumW]) begin
      sat_sum = {1'b1, {(qwdp_pkg::SumW-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(qwdp_pkg::SumW-1){1'b1}}};
    end
    clip_now = clip_q || ovf;
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      w_weight_q <= weight_d;
      w_act_q    <= head_i.act;
      w_last_q   <= head_i.last;
      p_prod_q   <= prod_d;
      p_last_q   <= w_last_q;
      if (p_valid_q && p_last_q) begin
        out_data_q <= sat_sum;
        out_user_q <= clip_now;
      end
    end
  end

  // Stage valids, running sum and clip flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q   <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
    end else if (advance) begin
      w_valid_q   <= pop_o;
      p_valid_q   <= w_valid_q;
      out_valid_q <= p_valid_q && p_last_q;
      if (p_valid_q) begin
        if (p_last_q) begin
          acc_q  <= '0;
          clip_q <= 1'b0;
        end else begin
          acc_q  <= sat_sum;
          clip_q <= clip_now;
        end
      end
    end
  end

endmodule

/* hdl/quantized_weight_dot_product_unit.sv */
// Top level of the quantized-weight dot product unit.
`timescale 1ns / 1ps

// Streaming dot product of Q3.12 activations against 2-, 4- or 8-bit quantized weights.
// The slave channel takes one element per item: activation, packed weight byte, block
// scale and block zero point in tdata, and tlast on the final element of a row. The
// master channel returns one item per row: the saturated Q.24 sum in tdata and, in tuser,
// a flag that the sum clipped at some point in the row.
// The configuration channel writes the 2-bit mode (0 two-bit, 1 four-bit, 2 or 3
// eight-bit signed); it is always ready and should be written only while the unit is idle.
// Throughput is one item per clock while the receiver does not stall. Each element passes
// from the queue through the dequantizing multiply into one register and through the
// activation multiply into the next, with the accumulate feeding the output register.
// When the receiver stalls, the result is held, the pipeline freezes and the
// four-entry queue fills; tready on the slave side then falls until space frees.
// Reset clears the sum, the clip flag, the block position and the queue, and sets the
// mode to four-bit.
module quantized_weight_dot_product_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // activation, packed_byte, block_scale, block_zero
  input  logic        s_axis_tlast,
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // dot_value
  output logic        m_axis_tuser    // saturated
);

  qwdp_pkg::item_t    push_item, head;
  qwdp_pkg::q_stat_t  q_stat;
  logic               push, pop;

  assign cfg_ready_o = 1'b1;

  // Front part: accept and classify.
  qwdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Queue between the two parts.
  qwdp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // Back part: arithmetic and result register.
  qwdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

/* tb/tb_quantized_weight_dot_product_unit.sv */
// Self-checking testbench for the quantized-weight dot product unit.
`timescale 1ns / 1ps

module tb_quantized_weight_dot_product_unit;

  // Mode code 3 has no name in the package; the unit treats it as eight-bit.
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam logic signed [47:0] DotMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] DotMin = {1'b1, {47{1'b0}}};
  localparam longint SumCeil  = (64'sd1 <<< (qwdp_pkg::SumW - 1)) - 64'sd1;
  localparam longint SumFloor = -SumCeil - 64'sd1;

  localparam int NumDirRows    = 20;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 10;
  localparam int PressurePhase = 4;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 8;
  localparam int StallLimit    = 2000;

  // One weight element as it travels on the slave channel.
  typedef struct packed {
    logic signed [15:0] act;
    logic [7:0]         wbyte;
    logic signed [15:0] scale;
    logic signed [23:0] zero;
    logic               last;
  } elem_t;

  // One row result as it travels on the master channel.
  typedef struct packed {
    logic [47:0] dot;
    logic        sat;
  } dot_result_t;

  // One line of the directed table; known marks a result typed in by hand.
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] act;
    logic [7:0]         wbyte;
    logic signed [15:0] scale;
    logic signed [23:0] zero;
    logic [15:0]        reps;
    logic               last;
    logic               known;
    logic signed [47:0] dot;
    logic               sat;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // activation, packed_byte, block_scale, block_zero
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // dot_value
  logic        m_axis_tuser;   // saturated

  quantized_weight_dot_product_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow of the unit's state, advanced on every accepted item.
  logic [1:0]  mode_q    = qwdp_pkg::ModeFourBit;
  longint      acc_sum   = 0;
  int unsigned blk_pos   = 0;
  bit          clip_flag = 1'b0;

  dot_result_t dot_expect_q[$];
  int          mismatches  = 0;
  int          stall_count = 0;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;
  bit          no_gaps     = 1'b0;
  int          burst_left  = 0;

  // Directed rows: reset mode, code selection, extremes, spare mode, clipping both ways.
  dir_row_t dir_rows [0:NumDirRows-1] = '{
    '{qwdp_pkg::ModeFourBit,  16'sh1000, 8'h21, 16'sh1000, 24'sh0,     16'd1,   1'b1, 1'b1,
      48'sh1000000, 1'b0},
    '{qwdp_pkg::ModeFourBit,  16'sh1000, 8'hF0, 16'sh1000, 24'sh0,     16'd1,   1'b0, 1'b0,
      48'sh0, 1'b0},
    '{qwdp_pkg::ModeFourBit,  16'sh1000, 8'hF0, 16'sh1000, 24'sh0,     16'd1,   1'b1, 1'b1,
      48'shF000000, 1'b0},
    '{qwdp_pkg::ModeFourBit,  16'sh1000, 8'h00, 16'sh0000, 24'sh001000, 16'd1,  1'b1, 1'b1,
      48'sh1000000, 1'b0},
    '{qwdp_pkg::ModeFourBit,  16'sh0000, 8'hFF, 16'sh7FFF, 24'sh7FFFFF, 16'd1,  1'b1, 1'b1,
      48'sh0, 1'b0},
    '{qwdp_pkg::ModeTwoBit,   16'sh1000, 8'hE4, 16'sh1000, 24'sh0,     16'd4,   1'b1, 1'b1,
      48'sh6000000, 1'b0},
    '{qwdp_pkg::ModeTwoBit,   -16'sd32768, 8'hFF, -16'sd32768, -24'sd8388608, 16'd3,
      1'b0, 1'b0, 48'sh0, 1'b0},
    '{qwdp_pkg::ModeTwoBit,   16'sh7FFF, 8'h1B, 16'sh7FFF, 24'sh7FFFFF, 16'd1,  1'b1, 1'b0,
      48'sh0, 1'b0},
    '{qwdp_pkg::ModeEightBit, 16'sh7FFF, 8'h80, 16'sh7FFF, 24'sh7FFFFF, 16'd1,  1'b1, 1'b1,
      -48'sd137430564992, 1'b0},
    '{qwdp_pkg::ModeEightBit, -16'sd32768, 8'h7F, -16'sd32768, -24'sd8388608, 16'd1,
      1'b1, 1'b1, 48'sd136365211648, 1'b0},
    '{qwdp_pkg::ModeEightBit, 16'sh1234, 8'h5A, 16'sh0ABC, 24'sh0,     16'd5,   1'b1, 1'b0,
      48'sh0, 1'b0},
    '{ModeSpare,              16'sh1000, 8'hFF, 16'sh1000, 24'sh123456, 16'd1,  1'b1, 1'b1,
      -48'sd16777216, 1'b0},
    '{qwdp_pkg::ModeFourBit,  16'sh7FFF, 8'hFF, 16'sh7FFF, 24'sh7FFFFF, 16'd490, 1'b0, 1'b0,
      48'sh0, 1'b0},
    '{qwdp_pkg::ModeFourBit,  16'sh1000, 8'h00, 16'sh0000, -24'sd4096, 16'd1,  1'b1, 1'b1,
      DotMax - 48'sd16777216, 1'b1},
    '{qwdp_pkg::ModeFourBit,  16'sh7FFF, 8'hFF, -16'sd32768, -24'sd8388608, 16'd490,
      1'b1, 1'b1, DotMin, 1'b1},
    '{qwdp_pkg::ModeFourBit,  16'sh7FFF, 8'hFF, -16'sd32768, -24'sd8388608, 16'd4,
      1'b1, 1'b0, 48'sh0, 1'b0},
    '{qwdp_pkg::ModeFourBit,  16'sh1000, 8'h01, 16'sh1000, 24'sh0,     16'd1,   1'b1, 1'b1,
      48'sh1000000, 1'b0},
    '{qwdp_pkg::ModeTwoBit,   16'sh1000, 8'hE4, 16'sh1000, 24'sh0,     16'd2,   1'b1, 1'b1,
      48'sh1000000, 1'b0},
    '{qwdp_pkg::ModeTwoBit,   16'sh1000, 8'hE4, 16'sh1000, 24'sh0,     16'd1,   1'b1, 1'b1,
      48'sh0, 1'b0},
    '{qwdp_pkg::ModeTwoBit,   16'sh1000, 8'hE4, 16'sh1000, 24'sh0,     16'd35,  1'b1, 1'b0,
      48'sh0, 1'b0}
  };

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Dequantize one element, multiply-accumulate with clamping, and return 1 on a row end.
  function automatic logic accumulate_element(input elem_t e, output dot_result_t res);
    longint act_v;
    longint code;
    longint wgt;
    longint total;
    act_v = longint'(e.act);
    case (mode_q)
      qwdp_pkg::ModeTwoBit: begin
        code = longint'((e.wbyte >> (2 * (blk_pos % 4))) & qwdp_pkg::TwoBitMask);
        wgt  = longint'(e.zero) + code * longint'(e.scale);
      end
      qwdp_pkg::ModeFourBit: begin
        code = longint'((e.wbyte >> (4 * (blk_pos % 2))) & qwdp_pkg::FourBitMask);
        wgt  = longint'(e.zero) + code * longint'(e.scale);
      end
      default: begin
        wgt = longint'($signed(e.wbyte)) * longint'(e.scale);
      end
    endcase
    total = acc_sum + act_v * wgt;
    if (total > SumCeil) begin
      total     = SumCeil;
      clip_flag = 1'b1;
    end else if (total < SumFloor) begin
      total     = SumFloor;
      clip_flag = 1'b1;
    end
    res = '0;
    if (e.last) begin
      res.dot   = total[47:0];
      res.sat   = clip_flag;
      acc_sum   = 0;
      clip_flag = 1'b0;
      blk_pos   = 0;
      return 1'b1;
    end
    acc_sum = total;
    blk_pos = (blk_pos + 1 >= qwdp_pkg::BlockElems) ? 0 : blk_pos + 1;
    return 1'b0;
  endfunction

  // Mostly random, with the field's minimum, maximum, zero and all-ones mixed in.
  function automatic logic [31:0] skew_value(input int unsigned w);
    logic [31:0] one;
    one = 32'd1;
    case ($urandom_range(0, 9))
      0:       return one << (w - 1);
      1:       return (one << (w - 1)) - 1;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic elem_t random_elem();
    elem_t e;
    e.act   = 16'(skew_value(16));
    e.wbyte = 8'(skew_value(8));
    e.scale = 16'(skew_value(16));
    e.zero  = 24'(skew_value(24));
    e.last  = 1'b0;
    return e;
  endfunction

  // Offer one item, wait for the handshake, then record what it should produce.
  task automatic send_elem(input elem_t e, input logic known, input logic [47:0] kdot,
                           input logic ksat);
    dot_result_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e.zero, e.scale, e.wbyte, e.act};
    s_axis_tlast  <= e.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (accumulate_element(e, res)) begin
      if (known) begin
        res.dot = kdot;
        res.sat = ksat;
      end
      dot_expect_q.push_back(res);
    end
  endtask

  // Random items go out in bursts with gaps between them unless the phase runs flat out.
  task automatic send_paced(input elem_t e);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    send_elem(e, 1'b0, '0, 1'b0);
  endtask

  // Stop offering items and let every outstanding result drain out of the pipeline.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (dot_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  // Receiver: random stall patterns, plus one long hold-off when the sender asks for it.
  initial begin : result_sink
    int style;
    int span;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(30, 150);
        repeat (span) begin
          case (style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ~m_axis_tready;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    dot_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dot_expect_q.size() == 0) begin
        $display("%0t: unexpected result, got dot_value %0d saturated %0b", $time,
                 $signed(m_axis_tdata), m_axis_tuser);
        mismatches++;
      end else begin
        want = dot_expect_q.pop_front();
        if (m_axis_tdata !== want.dot) begin
          $display("%0t: dot_value mismatch, expected %0d, got %0d", $time,
                   $signed(want.dot), $signed(m_axis_tdata));
          mismatches++;
        end
        if (m_axis_tuser !== want.sat) begin
          $display("%0t: saturated mismatch, expected %0b, got %0b", $time,
                   want.sat, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake means the unit has hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random phases under varying modes.
  initial begin : stimulus
    elem_t e;
    int    phase_items;
    int    len;
    bit    pressure;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; a mode change waits until the unit is idle.
    for (int r = 0; r < NumDirRows; r++) begin
      if (dir_rows[r].mode != mode_q) begin
        settle();
        write_mode(dir_rows[r].mode);
      end
      for (int k = 0; k < int'(dir_rows[r].reps); k++) begin
        e.act   = dir_rows[r].act;
        e.wbyte = dir_rows[r].wbyte;
        e.scale = dir_rows[r].scale;
        e.zero  = dir_rows[r].zero;
        e.last  = dir_rows[r].last && (k == int'(dir_rows[r].reps) - 1);
        send_elem(e, dir_rows[r].known, dir_rows[r].dot, dir_rows[r].sat);
      end
    end

    // Random phases; each ends on a row end so the mode can be changed safely.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      if (p == 0) write_mode(qwdp_pkg::ModeTwoBit);
      else if (p == 1) write_mode(ModeSpare);
      else write_mode(2'($urandom_range(0, 3)));
      pressure    = (p == PressurePhase);
      hold_req    = pressure;
      no_gaps     = pressure || ($urandom_range(0, 3) == 0);
      burst_left  = 0;
      phase_items = 0;
      while (phase_items < ItemsPerPhase || (pressure && !hold_done)) begin
        if (pressure) len = $urandom_range(1, 3);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(9, 48);
        else len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          e      = random_elem();
          e.last = (k == len - 1);
          send_paced(e);
        end
        phase_items += len;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
